>>> hdl/modexp_pkg.sv
// shared constants and types for the modular exponentiation block
package modexp_pkg;

  // width of the modulus, the base, the exponent and the result
  localparam int OPERAND_WIDTH = 31;

  // width of a counter that holds one bit position of an operand
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  // status of the bit-serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

>>> hdl/modexp_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module modexp_mulmod (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0]   mul_a,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0]   mul_b,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0]   modulus,
  output logic [modexp_pkg::OPERAND_WIDTH-1:0]   product,
  output modexp_pkg::mm_stat_t                   stat
);

  logic [modexp_pkg::OPERAND_WIDTH-1:0] acc_r, acc_nxt;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] a_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] mplr_r;
  logic [modexp_pkg::CNT_W-1:0]         cnt_r;
  logic                                 busy_r;
  logic                                 done_r;

  logic [modexp_pkg::OPERAND_WIDTH:0] mod_ext;
  logic [modexp_pkg::OPERAND_WIDTH:0] dbl;
  logic [modexp_pkg::OPERAND_WIDTH:0] red1;
  logic [modexp_pkg::OPERAND_WIDTH:0] sum;
  logic [modexp_pkg::OPERAND_WIDTH:0] red2;

  // double the partial product, reduce, then add the multiplicand where the bit is set
  always_comb begin
    mod_ext = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    red1    = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = red1 + {1'b0, a_r};
    red2    = (sum >= mod_ext) ? sum - mod_ext : sum;
    acc_nxt = mplr_r[modexp_pkg::OPERAND_WIDTH-1] ?
              red2[modexp_pkg::OPERAND_WIDTH-1:0] : red1[modexp_pkg::OPERAND_WIDTH-1:0];
  end

  // control: busy while the multiplier bits are worked through, done pulses after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: operand load and one shift-add-reduce step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= mul_a;
      mplr_r <= mul_b;
      acc_r  <= '0;
      cnt_r  <= modexp_pkg::CNT_W'(modexp_pkg::OPERAND_WIDTH - 1);
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      mplr_r <= {mplr_r[modexp_pkg::OPERAND_WIDTH-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign product    = acc_r;
  assign stat.busy  = busy_r;
  assign stat.done  = done_r;

`ifndef SYNTHESIS
  // a new product is never started on top of one in progress
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("mulmod started while busy");

  // the partial product stays reduced below a modulus of at least 2
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (modulus >= modexp_pkg::OPERAND_WIDTH'(2))) |-> (acc_r < modulus))
    else $error("mulmod partial product not reduced");

  // done is a single-cycle pulse that ends a busy run
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("mulmod done without a finished run");
`endif

endmodule

>>> hdl/modular_exponentiation.sv
// top level: modular exponentiation by right-to-left square-and-multiply
// Computes power_mod = base^exponent mod modulus, one result per input transfer.
// The modulus is written through the cfg port while the block is idle (cfg_ready
// is high only then, and a cfg write being offered holds off the input for that
// cycle); a modulus below 2 gives a result of 0. All arithmetic runs
// through one bit-serial modular multiplier: one product to reduce the base,
// then for each of the OPERAND_WIDTH exponent bits one squaring plus one
// multiply where the bit is 1. The input is taken only while idle; a
// finished result waits in the output register while the next input is taken.
module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] in_base,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] in_exponent,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [modexp_pkg::OPERAND_WIDTH-1:0] out_power_mod,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] cfg_modulus
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SQR  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                               state_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] modulus_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] base_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] exp_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] run_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] acc_r;
  logic [modexp_pkg::CNT_W-1:0]         bit_cnt_r;
  logic                                 go_r;
  logic                                 out_valid_r;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] out_power_mod_r;

  logic                                 in_xfer;
  logic                                 out_load;
  logic                                 last_bit;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] mm_a;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] mm_b;
  logic [modexp_pkg::OPERAND_WIDTH-1:0] mm_product;
  modexp_pkg::mm_stat_t                 mm_stat;

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign last_bit  = (bit_cnt_r == modexp_pkg::CNT_W'(modexp_pkg::OPERAND_WIDTH - 1));

  // multiplier operands by phase: base reduction is 1 * base mod m
  always_comb begin
    case (state_r)
      S_RED: begin
        mm_a = modexp_pkg::OPERAND_WIDTH'(1);
        mm_b = base_r;
      end
      S_MUL: begin
        mm_a = acc_r;
        mm_b = run_r;
      end
      default: begin
        mm_a = run_r;
        mm_b = run_r;
      end
    endcase
  end

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (go_r),
    .mul_a   (mm_a),
    .mul_b   (mm_b),
    .modulus (modulus_r),
    .product (mm_product),
    .stat    (mm_stat)
  );

  // modulus register, written on a cfg transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= modexp_pkg::OPERAND_WIDTH'(2);
    end else if (cfg_valid && cfg_ready) begin
      modulus_r <= cfg_modulus;
    end
  end

  // sequencer: reduce, then multiply where the bit is set and square, per bit; a modulus below 2 goes straight to done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (modulus_r < modexp_pkg::OPERAND_WIDTH'(2)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RED;
              go_r    <= 1'b1;
            end
          end
        end
        S_RED: begin
          if (mm_stat.done) begin
            state_r <= exp_r[0] ? S_MUL : S_SQR;
            go_r    <= 1'b1;
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            state_r <= S_SQR;
            go_r    <= 1'b1;
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            if (last_bit) begin
              state_r <= S_DONE;
            end else begin
              state_r <= exp_r[1] ? S_MUL : S_SQR;
              go_r    <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // working values of the exponentiation
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_r    <= in_base;
      exp_r     <= in_exponent;
      bit_cnt_r <= '0;
      acc_r     <= (modulus_r < modexp_pkg::OPERAND_WIDTH'(2)) ?
                   '0 : modexp_pkg::OPERAND_WIDTH'(1);
    end else if (mm_stat.done) begin
      case (state_r)
        S_RED: run_r <= mm_product;
        S_MUL: acc_r <= mm_product;
        S_SQR: begin
          run_r     <= mm_product;
          exp_r     <= {1'b0, exp_r[modexp_pkg::OPERAND_WIDTH-1:1]};
          bit_cnt_r <= bit_cnt_r + 1'b1;
        end
        default: begin
          run_r <= run_r;
        end
      endcase
    end
  end

  // output register, freed by an out transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_power_mod_r <= acc_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_power_mod_r;

`ifndef SYNTHESIS
  // a stalled result keeps its value until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_power_mod_r)))
    else $error("result changed while stalled");

  // the sequencer sits in exactly one state
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  // the multiplier is quiet whenever no item is being worked on
  a_mm_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_DONE)) |-> !mm_stat.busy)
    else $error("multiplier busy outside a computation");
`endif

endmodule
